>>> design/utf8_stream_decoder_top_macros.svh
// Assertion macros used by the checker of the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define U8SD_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define U8SD_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> design/u8sd_pkg.sv
// Types, constants and byte classification for the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] REPL_CP    = 21'h00FFFD;
  localparam logic [CpW-1:0] MAX_CP     = 21'h10FFFF;
  localparam logic [CpW-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CpW-1:0] MIN_CP_L2  = 21'h000080;
  localparam logic [CpW-1:0] MIN_CP_L3  = 21'h000800;
  localparam logic [CpW-1:0] MIN_CP_L4  = 21'h010000;

  // Byte class as seen at the head of a window.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_t;

  // One buffered byte together with its class.
  typedef struct packed {
    logic [7:0] data;
    byte_cls_t  cls;
  } pend_t;

  // One request as it sits in the queue between front and back.
  typedef struct packed {
    pend_t ent;
    logic  last;
  } q_item_t;

  // Classify a raw byte by its high bits.
  function automatic byte_cls_t classify(input logic [7:0] b);
    byte_cls_t c;
    if ((b & 8'h80) == 8'h00) c = CLS_ASCII;
    else if ((b & 8'hC0) == 8'h80) c = CLS_CONT;
    else if ((b & 8'hE0) == 8'hC0) c = CLS_LEAD2;
    else if ((b & 8'hF0) == 8'hE0) c = CLS_LEAD3;
    else if ((b & 8'hF8) == 8'hF0) c = CLS_LEAD4;
    else c = CLS_BAD;
    return c;
  endfunction

  // Window length that a head byte of this class asks for.
  function automatic logic [2:0] cls_len(input byte_cls_t c);
    logic [2:0] n;
    unique case (c)
      CLS_LEAD2: n = 3'd2;
      CLS_LEAD3: n = 3'd3;
      CLS_LEAD4: n = 3'd4;
      default:   n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic is_lead(input byte_cls_t c);
    return (c == CLS_LEAD2) || (c == CLS_LEAD3) || (c == CLS_LEAD4);
  endfunction

endpackage

>>> design/u8sd_if.sv
// Valid/ready channel interfaces for the input bytes and the decoded code points.
interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source(output valid, output text_byte, output is_last, input ready);
  modport sink(input valid, input text_byte, input is_last, output ready);
endinterface

interface u8sd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        run_end;
  logic        text_done;

  modport source(output valid, output code_point, output replaced, output run_end,
                 output text_done, input ready);
  modport sink(input valid, input code_point, input replaced, input run_end,
               input text_done, output ready);
endinterface

>>> design/utf8_stream_decoder_top.sv
// UTF-8 stream decoder: bytes with an end-of-text flag in, Unicode code points out.
//
// in_bus carries one request per byte (text_byte, is_last); out_bus carries one
// request per decoded code point (code_point, replaced, run_end, text_done).
// Both are valid/ready channels; a request moves when valid and ready are high.
// A byte may cause zero to four results. run_end marks the last result of a
// byte and text_done the last result of the whole text; the window is cleared
// after a byte with is_last set, so the next byte starts a new text.
// The decode stage makes a byte's first result from the queue output and
// registers it; a busy back end or a stalled out_bus holds the byte queued.
// Throughput: one byte per cycle while each byte gives at most one result and
// out_bus is not stalled; a byte that gives several results holds the decode
// stage until its last one, one per cycle from the four-byte window if unstalled.
// A two-entry queue separates byte intake from decoding.
// Reset empties the queue, the window and the output register.
// When the receiver holds out_bus.ready low, the result waits in the output
// register, decoding pauses, the queue fills and then in_bus.ready drops.
module utf8_stream_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  u8sd_in_if.sink    in_bus,
  u8sd_out_if.source out_bus
);

  logic              q_valid;
  logic              q_ready;
  u8sd_pkg::q_item_t q_item;

  u8sd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  u8sd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready),
    .out_bus (out_bus)
  );

endmodule

>>> design/u8sd_front.sv
// Front end: accepts byte requests, classifies them and queues them for the back end.
module u8sd_front (
  input  logic              clk,
  input  logic              rst_n,
  u8sd_in_if.sink           in_bus,
  output logic              q_valid,
  output u8sd_pkg::q_item_t q_item,
  input  logic              q_ready
);

  u8sd_pkg::q_item_t mem_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  u8sd_pkg::q_item_t new_item;

  // Classify the incoming byte on the way into the queue.
  always_comb begin
    new_item.ent.data = in_bus.text_byte;
    new_item.ent.cls  = u8sd_pkg::classify(in_bus.text_byte);
    new_item.last     = in_bus.is_last;
  end

  assign in_bus.ready = (cnt_r != 2'd2);
  assign push         = in_bus.valid && in_bus.ready;
  assign q_valid      = (cnt_r != 2'd0);
  assign pop          = q_valid && q_ready;
  assign q_item       = mem_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = push ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= new_item;
    end
  end

endmodule

>>> design/u8sd_back.sv
// Back end: byte window and output register; decodes one result per cycle while not stalled.
module u8sd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  u8sd_pkg::q_item_t q_item,
  output logic              q_ready,
  u8sd_out_if.source        out_bus
);

  // Window state: up to four buffered bytes, oldest first.
  u8sd_pkg::pend_t buf_r [4];
  logic [2:0]      cnt_r;
  logic            last_r;
  logic            busy_r;

  // Output register.
  logic                         out_valid_r;
  logic [u8sd_pkg::CpW-1:0]     cp_r;
  logic                         repl_r;
  logic                         run_end_r;
  logic                         done_r;

  u8sd_pkg::pend_t          w   [4];
  u8sd_pkg::pend_t          rem [4];
  logic [2:0]               wcnt;
  logic                     wlast;
  logic                     active;
  u8sd_pkg::pend_t          head;
  u8sd_pkg::pend_t          nh;
  logic [2:0]               hlen;
  logic [2:0]               nh_len;
  logic [1:0]               bad;
  logic [u8sd_pkg::CpW-1:0] cp_asm;
  logic                     invalid;
  logic                     wait_step;
  logic [2:0]               drop;
  logic [2:0]               cnt_nxt;
  logic [u8sd_pkg::CpW-1:0] res_cp;
  logic                     res_repl;
  logic                     more;
  logic                     out_free;
  logic                     fire;

  // Effective window: when idle, the queued byte is appended behind the buffer.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = buf_r[i];
      if (!busy_r && (cnt_r == 3'(i))) begin
        w[i] = q_item.ent;
      end
    end
    wcnt   = busy_r ? cnt_r : cnt_r + 3'd1;
    wlast  = busy_r ? last_r : q_item.last;
    active = busy_r || q_valid;
  end

  // Assemble the scalar value and find the first bad continuation byte.
  always_comb begin
    head = w[0];
    hlen = u8sd_pkg::cls_len(head.cls);
    unique case (head.cls)
      u8sd_pkg::CLS_LEAD2: cp_asm = {10'd0, head.data[4:0], w[1].data[5:0]};
      u8sd_pkg::CLS_LEAD3: cp_asm = {5'd0, head.data[3:0], w[1].data[5:0],
                                     w[2].data[5:0]};
      u8sd_pkg::CLS_LEAD4: cp_asm = {head.data[2:0], w[1].data[5:0],
                                     w[2].data[5:0], w[3].data[5:0]};
      default:             cp_asm = {13'd0, head.data};
    endcase
    bad = 2'd0;
    for (int i = 3; i >= 1; i--) begin
      if ((3'(i) < hlen) && (w[i].cls != u8sd_pkg::CLS_CONT)) begin
        bad = 2'(i);
      end
    end
    invalid = ((head.cls == u8sd_pkg::CLS_LEAD2) && (cp_asm < u8sd_pkg::MIN_CP_L2)) ||
              ((head.cls == u8sd_pkg::CLS_LEAD3) && (cp_asm < u8sd_pkg::MIN_CP_L3)) ||
              ((head.cls == u8sd_pkg::CLS_LEAD4) && (cp_asm < u8sd_pkg::MIN_CP_L4)) ||
              (cp_asm > u8sd_pkg::MAX_CP) ||
              ((cp_asm >= u8sd_pkg::SURR_LO) && (cp_asm <= u8sd_pkg::SURR_HI));
  end

  // Pick the outcome for the head of the window.
  always_comb begin
    wait_step = 1'b0;
    drop      = 3'd1;
    res_cp    = u8sd_pkg::REPL_CP;
    res_repl  = 1'b1;
    priority if (head.cls == u8sd_pkg::CLS_ASCII) begin
      res_cp   = {13'd0, head.data};
      res_repl = 1'b0;
    end else if (!u8sd_pkg::is_lead(head.cls)) begin
      drop = 3'd1;
    end else if (wcnt < hlen) begin
      // Window not yet complete: end of text flushes it, otherwise wait.
      if (wlast) begin
        drop = wcnt;
      end else begin
        wait_step = 1'b1;
        drop      = 3'd0;
      end
    end else if (bad != 2'd0) begin
      drop = {1'b0, bad};
    end else begin
      drop = hlen;
      if (!invalid) begin
        res_cp   = cp_asm;
        res_repl = 1'b0;
      end
    end
  end

  // Shift out consumed bytes and look ahead for another result in this request.
  always_comb begin
    cnt_nxt = wcnt - drop;
    for (int i = 0; i < 4; i++) begin
      rem[i] = w[2'(i) + drop[1:0]];
    end
    nh     = w[drop[1:0]];
    nh_len = u8sd_pkg::cls_len(nh.cls);
    more   = (cnt_nxt != 3'd0) &&
             !(u8sd_pkg::is_lead(nh.cls) && (cnt_nxt < nh_len) && !wlast);
  end

  assign out_free = !out_valid_r || out_bus.ready;
  assign fire     = active && (wait_step || out_free);
  assign q_ready  = fire && !busy_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= 3'd0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cnt_r  <= cnt_nxt;
        busy_r <= !wait_step && more;
        last_r <= wlast;
      end
      if (fire && !wait_step) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Window bytes and result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < 4; i++) begin
        buf_r[i] <= rem[i];
      end
    end
    if (fire && !wait_step) begin
      cp_r      <= res_cp;
      repl_r    <= res_repl;
      run_end_r <= !more;
      done_r    <= !more && wlast;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.code_point = cp_r;
  assign out_bus.replaced   = repl_r;
  assign out_bus.run_end    = run_end_r;
  assign out_bus.text_done  = done_r;

endmodule

>>> design/u8sd_checker.sv
// Port-level checker for the UTF-8 stream decoder and its bind to the top level.
`include "utf8_stream_decoder_top_macros.svh"

module u8sd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic        replaced,
  input logic        run_end,
  input logic        text_done
);

  // A stalled result stays offered.
  `U8SD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `U8SD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(code_point) && $stable(replaced) && $stable(run_end) && $stable(text_done), "result changed while stalled")

  // A replaced result always carries the replacement character.
  `U8SD_ASSERT_IMP(a_repl_cp, out_valid && replaced, code_point == u8sd_pkg::REPL_CP, "replaced result without U+FFFD")

  // A decoded value is a Unicode scalar value.
  `U8SD_ASSERT_IMP(a_scalar, out_valid && !replaced, (code_point <= u8sd_pkg::MAX_CP) && ((code_point < u8sd_pkg::SURR_LO) || (code_point > u8sd_pkg::SURR_HI)), "decoded value is not a scalar value")

  // The end of the text is also the end of that byte's results.
  `U8SD_ASSERT_IMP(a_done_end, out_valid && text_done, run_end, "text end without run end")

endmodule

bind utf8_stream_decoder_top u8sd_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .code_point (out_bus.code_point),
  .replaced   (out_bus.replaced),
  .run_end    (out_bus.run_end),
  .text_done  (out_bus.text_done)
);

>>> sim/utf8_stream_decoder_top_test.sv
// Self-checking testbench for the UTF-8 stream decoder with randomized handshakes.
`timescale 1ns / 100ps

module utf8_stream_decoder_top_test;

  localparam int unsigned BYTE_TARGET    = 430;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  // One byte request waiting to be sent, with a flag that holds it until all results are in.
  typedef struct {
    logic [7:0] text_byte;
    logic       is_last;
    bit         drain_first;
  } byte_req_t;

  // One decoded code point as the block should give it.
  typedef struct packed {
    logic [u8sd_pkg::CpW-1:0] code_point;
    logic                     replaced;
    logic                     run_end;
    logic                     text_done;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  u8sd_in_if  in_bus ();
  u8sd_out_if out_bus ();

  utf8_stream_decoder_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  byte_req_t   send_q [$];
  cp_result_t  owed_q [$];
  logic [7:0]  window_bytes [4];
  int unsigned window_count;
  int unsigned results_owed;
  int unsigned bytes_taken;
  int unsigned bytes_total;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_gap;
  int unsigned sink_stall;
  bit          src_calm;
  bit          sink_calm;
  bit          drain_next;

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cp_result_t make_result(logic [u8sd_pkg::CpW-1:0] cp, logic repl);
    cp_result_t r;
    r.code_point = cp;
    r.replaced   = repl;
    r.run_end    = 1'b0;
    r.text_done  = 1'b0;
    return r;
  endfunction

  // Drop the k oldest bytes of the decode window.
  function automatic void shift_window(int unsigned k);
    if (k >= window_count) begin
      window_count = 0;
    end else begin
      for (int i = 0; i + k < window_count; i++) window_bytes[i] = window_bytes[i + k];
      window_count = window_count - k;
    end
  endfunction

  // Add one byte to the window and queue every code point it completes.
  function automatic void decode_byte(logic [7:0] b, logic last);
    cp_result_t               res [$];
    cp_result_t               r;
    logic [7:0]               lead;
    logic [7:0]               c;
    logic [u8sd_pkg::CpW-1:0] cp;
    int unsigned              len;
    int unsigned              bad;
    bit                       stop;
    bit                       invalid;
    window_bytes[window_count] = b;
    window_count++;
    stop = 0;
    while (window_count > 0 && res.size() < 4 && !stop) begin
      lead = window_bytes[0];
      if (!lead[7]) begin
        res.insert(res.size(), make_result({14'd0, lead[6:0]}, 1'b0));
        shift_window(1);
      end else if (lead[7:5] == 3'b110 || lead[7:4] == 4'b1110 || lead[7:3] == 5'b11110) begin
        len = lead[5] ? (lead[4] ? 4 : 3) : 2;
        if (window_count < len) begin
          // Text ends inside the window: one replacement, the window is dropped.
          if (last) begin
            res.insert(res.size(), make_result(u8sd_pkg::REPL_CP, 1'b1));
            window_count = 0;
          end
          stop = 1;
        end else begin
          bad = 0;
          cp = (len == 2) ? {16'd0, lead[4:0]} :
               (len == 3) ? {17'd0, lead[3:0]} : {18'd0, lead[2:0]};
          for (int i = 1; i < len && bad == 0; i++) begin
            c = window_bytes[i];
            if (c[7:6] != 2'b10) bad = i;
            else cp = {cp[14:0], c[5:0]};
          end
          if (bad != 0) begin
            // Bad continuation: replace, then restart from the offending byte.
            res.insert(res.size(), make_result(u8sd_pkg::REPL_CP, 1'b1));
            shift_window(bad);
          end else begin
            shift_window(len);
            invalid = (len == 2 && cp < u8sd_pkg::MIN_CP_L2) ||
                      (len == 3 && cp < u8sd_pkg::MIN_CP_L3) ||
                      (len == 4 && cp < u8sd_pkg::MIN_CP_L4) || cp > u8sd_pkg::MAX_CP ||
                      (cp >= u8sd_pkg::SURR_LO && cp <= u8sd_pkg::SURR_HI);
            res.insert(res.size(), invalid ? make_result(u8sd_pkg::REPL_CP, 1'b1) :
                                             make_result(cp, 1'b0));
          end
        end
      end else begin
        // Continuation or 0xF8..0xFF at the head of the window.
        res.insert(res.size(), make_result(u8sd_pkg::REPL_CP, 1'b1));
        shift_window(1);
      end
    end
    if (last) window_count = 0;
    foreach (res[k]) begin
      r = res[k];
      r.run_end   = (k == res.size() - 1);
      r.text_done = (k == res.size() - 1) && last;
      owed_q.insert(owed_q.size(), r);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_byte(logic [7:0] b, logic last);
    byte_req_t req;
    req.text_byte   = b;
    req.is_last     = last;
    req.drain_first = drain_next;
    drain_next      = 0;
    send_q.insert(send_q.size(), req);
  endtask

  // Encode v in len bytes, send the first keep of them, and replace byte spoil when nonzero.
  task automatic push_char(logic [20:0] v, int unsigned len, int unsigned keep,
                           int unsigned spoil);
    logic [7:0] seq [4];
    unique case (len)
      1: seq[0] = {1'b0, v[6:0]};
      2: begin
        seq[0] = {3'b110, v[10:6]};
        seq[1] = {2'b10, v[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, v[15:12]};
        seq[1] = {2'b10, v[11:6]};
        seq[2] = {2'b10, v[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, v[20:18]};
        seq[1] = {2'b10, v[17:12]};
        seq[2] = {2'b10, v[11:6]};
        seq[3] = {2'b10, v[5:0]};
      end
    endcase
    if (spoil != 0) seq[spoil] = 8'($urandom_range(0, 255));
    for (int i = 0; i < keep; i++) push_byte(seq[i], 1'b0);
  endtask

  // Stimulus: directed bytes, then random texts made mostly of well-formed characters.
  initial begin : stimulus
    logic [8:0]  directed_bytes [25];
    byte_req_t   tail;
    int unsigned nchars;
    int unsigned kind;
    int unsigned len;
    int unsigned text_idx;
    logic [20:0] v;
    in_bus.valid     = 1'b0;
    in_bus.text_byte = 8'h00;
    in_bus.is_last   = 1'b0;
    out_bus.ready    = 1'b0;
    // Bit 8 marks the final byte of a text.
    directed_bytes = '{9'h000, 9'h17F, 9'h080, 9'h0FF, 9'h0C2, 9'h080, 9'h0C1, 9'h0BF,
                       9'h0ED, 9'h0A0, 9'h080, 9'h0F4, 9'h090, 9'h080, 9'h080, 9'h0F0,
                       9'h080, 9'h0F8, 9'h041, 9'h0E2, 9'h182, 9'h0F4, 9'h08F, 9'h0BF,
                       9'h1BF};
    foreach (directed_bytes[i]) push_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    text_idx = 0;
    while (send_q.size() < BYTE_TARGET) begin
      if (text_idx % 12 == 0) drain_next = 1;
      nchars = $urandom_range(1, 10);
      for (int n = 0; n < nchars; n++) begin
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 4);
        if (kind < 55) begin
          unique case (len)
            1: v = 21'($urandom_range(0, 8'h7F));
            2: v = 21'($urandom_range(12'h080, 12'h7FF));
            3: begin
              v = 21'($urandom_range(16'h0800, 16'hF7FF));
              if (v >= 21'h00D800) v = v + 21'h000800;
            end
            default: v = 21'($urandom_range(21'h010000, 21'h10FFFF));
          endcase
          push_char(v, len, len, 0);
        end else if (kind < 63) begin
          // Truncated sequence; the next byte breaks or ends it.
          len = $urandom_range(2, 4);
          push_char(21'($urandom_range(0, 21'h1FFFFF)), len, $urandom_range(1, len - 1), 0);
        end else if (kind < 71) begin
          len = $urandom_range(2, 4);
          push_char(21'($urandom_range(0, 21'h1FFFFF)), len, len, $urandom_range(1, len - 1));
        end else if (kind < 77) begin
          len = $urandom_range(2, 4);
          v = (len == 2) ? 21'($urandom_range(0, 12'h07F)) :
              (len == 3) ? 21'($urandom_range(0, 12'h7FF)) : 21'($urandom_range(0, 16'hFFFF));
          push_char(v, len, len, 0);
        end else if (kind < 81) begin
          push_char(21'($urandom_range(21'h00D800, 21'h00DFFF)), 3, 3, 0);
        end else if (kind < 85) begin
          push_char(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 4, 0);
        end else begin
          push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
      tail = send_q.pop_back();
      tail.is_last = 1'b1;
      send_q.insert(send_q.size(), tail);
      text_idx++;
    end
    bytes_total = send_q.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < bytes_total || results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Driver: presents queued requests with random gaps, holding each until it is taken.
  always @(posedge clk) begin : drive_proc
    byte_req_t req;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_bus.valid && !in_bus.ready)) begin
      if (in_bus.valid) begin
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        send_gap = src_calm ? 0 : pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (send_q.size() > 0 &&
                   (!send_q[0].drain_first || (!in_bus.valid && results_owed == 0))) begin
        req = send_q.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.text_byte <= req.text_byte;
        in_bus.is_last   <= req.is_last;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each taken byte, checks each taken result, and stalls the sink.
  always @(posedge clk) begin : watch_proc
    cp_result_t want;
    bit         take;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      results_owed  <= 0;
      bytes_taken   <= 0;
      window_count  = 0;
      sink_stall    = 0;
      owed_q.delete();
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        decode_byte(in_bus.text_byte, in_bus.is_last);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: code_point 0x%0h", out_bus.code_point);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          check_field("code_point", 32'(want.code_point), 32'(out_bus.code_point));
          check_field("replaced", 32'(want.replaced), 32'(out_bus.replaced));
          check_field("run_end", 32'(want.run_end), 32'(out_bus.run_end));
          check_field("text_done", 32'(want.text_done), 32'(out_bus.text_done));
        end
      end
      results_owed <= owed_q.size();

      // Sink back-pressure, with calm stretches where ready stays high.
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      if (sink_stall == 0 && !sink_calm && $urandom_range(0, 99) < 30) sink_stall = pick_gap();
      take = (sink_stall == 0);
      if (sink_stall > 0) sink_stall--;
      out_bus.ready <= take;
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> sim.f
+incdir+design
design/u8sd_pkg.sv
design/u8sd_if.sv
design/u8sd_front.sv
design/u8sd_back.sv
design/utf8_stream_decoder_top.sv
design/u8sd_checker.sv
sim/utf8_stream_decoder_top_test.sv
